[src/signed_radix4_scalar_recoder_defines.svh]
// ----------------------------------------------------------------------------
// signed radix-4 scalar recoder: assertion macros
// shared property templates for the port-level checker
// ----------------------------------------------------------------------------
`ifndef SIGNED_RADIX4_SCALAR_RECODER_DEFINES_SVH
`define SIGNED_RADIX4_SCALAR_RECODER_DEFINES_SVH

// same-cycle implication, checked outside reset
`define SRR_ASSERT_NOW(lbl, clk, rst_n, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |-> (post)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define SRR_ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |=> (post)) \
        else $error(msg);

`endif

[src/srr_pkg.sv]
// ----------------------------------------------------------------------------
// srr_pkg
// shared constants and types of the signed radix-4 scalar recoder
// ----------------------------------------------------------------------------
`default_nettype none

package srr_pkg;

    localparam int WORD_WIDTH_DEF = 32;   // scalar word width, must be even
    localparam int QUEUE_DEPTH    = 2;    // front-to-back queue, power of two
    localparam int DIGIT_W        = 4;    // signed digit width
    localparam int OUT_TDATA_W    = 8;    // digit padded to a byte

    localparam logic [DIGIT_W-1:0] DIGIT_BIAS = 4'd4;

    // classification that travels with each queued word
    typedef struct packed {
        logic last_word;   // most significant word of the scalar
        logic word_zero;   // word has no set bit
    } t_item_ctrl;

endpackage

`default_nettype wire

[src/signed_radix4_scalar_recoder.sv]
// ----------------------------------------------------------------------------
// signed_radix4_scalar_recoder
// recodes a multiword scalar into signed radix-4 digits, lsb first
// ----------------------------------------------------------------------------
//  channel   dir  tdata (lsb up)              tlast
//  s_axis    in   scalar_word[WORD_WIDTH-1:0] last_word
//  m_axis    out  digit[3:0], zero pad [7:4]  last_digit
//
//  a non-last word gives the digit held from the word before, if any, and
//  WORD_WIDTH/2-1 digits of its own (16 at the default width once a digit is
//  held); a last word up to WORD_WIDTH/2+1; the sequencer emits one digit per
//  cycle while the output register is not stalled
//  the two-entry word queue fills while the sequencer works, and the next
//  word loads in the cycle the previous one finishes
//  synchronous active-low reset clears the queue, the held digit and carry
//  a stalled output register holds the sequencer; s_axis stalls only when
//  the queue is full
// ----------------------------------------------------------------------------
`default_nettype none

module signed_radix4_scalar_recoder #(
    parameter int WORD_WIDTH = srr_pkg::WORD_WIDTH_DEF   // even, 8..64
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // scalar words
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [((WORD_WIDTH+7)/8)*8-1:0]     s_axis_tdata,  // scalar_word
    input  logic                                s_axis_tlast,  // last_word
    // digits
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [srr_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,  // digit, zero pad
    output logic                                m_axis_tlast   // last_digit
);
    import srr_pkg::*;

    // front to back queue
    logic                  w_q_valid;
    logic                  w_q_ready;
    logic [WORD_WIDTH-1:0] w_q_word;
    t_item_ctrl            w_q_ctrl;
    logic [DIGIT_W-1:0]    w_digit;

    // word intake and classification
    srr_front #(
        .WORD_WIDTH (WORD_WIDTH)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_valid (s_axis_tvalid),
        .o_s_ready (s_axis_tready),
        .i_word    (s_axis_tdata[WORD_WIDTH-1:0]),
        .i_last    (s_axis_tlast),
        .o_q_valid (w_q_valid),
        .i_q_ready (w_q_ready),
        .o_q_word  (w_q_word),
        .o_q_ctrl  (w_q_ctrl)
    );

    // digit sequencer with the output register
    srr_back #(
        .WORD_WIDTH (WORD_WIDTH)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (w_q_valid),
        .o_q_ready (w_q_ready),
        .i_q_word  (w_q_word),
        .i_q_ctrl  (w_q_ctrl),
        .o_valid   (m_axis_tvalid),
        .i_ready   (m_axis_tready),
        .o_digit   (w_digit),
        .o_last    (m_axis_tlast)
    );

    // digit in the low nibble, upper bits zero
    assign m_axis_tdata = {{(OUT_TDATA_W-DIGIT_W){1'b0}}, w_digit};

endmodule

`default_nettype wire

[src/srr_front.sv]
// ----------------------------------------------------------------------------
// srr_front
// accepts scalar words, tags them and buffers them in a short queue
// ----------------------------------------------------------------------------
`default_nettype none

module srr_front #(
    parameter int WORD_WIDTH = srr_pkg::WORD_WIDTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_valid,
    output logic                  o_s_ready,
    input  logic [WORD_WIDTH-1:0] i_word,
    input  logic                  i_last,
    output logic                  o_q_valid,
    input  logic                  i_q_ready,
    output logic [WORD_WIDTH-1:0] o_q_word,
    output srr_pkg::t_item_ctrl   o_q_ctrl
);
    import srr_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    logic [WORD_WIDTH-1:0] r_word [QUEUE_DEPTH];
    t_item_ctrl            r_ctrl [QUEUE_DEPTH];
    logic [PTR_W-1:0]      r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0]      r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0]      r_count,  n_count;

    logic       w_push;
    logic       w_pop;
    t_item_ctrl w_ctrl;

    assign o_s_ready = (r_count != CNT_W'(QUEUE_DEPTH));
    assign o_q_valid = (r_count != '0);
    assign w_push    = i_s_valid && o_s_ready;
    assign w_pop     = o_q_valid && i_q_ready;

    // classify the incoming word
    assign w_ctrl.last_word = i_last;
    assign w_ctrl.word_zero = (i_word == '0);

    assign o_q_word = r_word[r_rd_ptr];
    assign o_q_ctrl = r_ctrl[r_rd_ptr];

    always_comb begin
        n_wr_ptr = w_push ? r_wr_ptr + PTR_W'(1) : r_wr_ptr;
        n_rd_ptr = w_pop  ? r_rd_ptr + PTR_W'(1) : r_rd_ptr;
        n_count  = r_count;
        if (w_push && !w_pop) begin
            n_count = r_count + CNT_W'(1);
        end else if (w_pop && !w_push) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_word[r_wr_ptr] <= i_word;
            r_ctrl[r_wr_ptr] <= w_ctrl;
        end
    end

endmodule

`default_nettype wire

[src/srr_back.sv]
// ----------------------------------------------------------------------------
// srr_back
// digit sequencer: one signed radix-4 digit per unstalled cycle into an output register
// ----------------------------------------------------------------------------
`default_nettype none

module srr_back #(
    parameter int WORD_WIDTH = srr_pkg::WORD_WIDTH_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_q_valid,
    output logic                        o_q_ready,
    input  logic [WORD_WIDTH-1:0]       i_q_word,
    input  srr_pkg::t_item_ctrl         i_q_ctrl,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [srr_pkg::DIGIT_W-1:0] o_digit,
    output logic                        o_last
);
    import srr_pkg::*;

    localparam int HALF  = WORD_WIDTH / 2;
    localparam int CNT_W = $clog2(HALF);

    // sequencer state
    logic                  r_busy,  n_busy;
    logic [WORD_WIDTH-1:0] r_w,     n_w;      // word, shifted down two bits per own digit
    logic                  r_last,  n_last;
    logic                  r_pend,  n_pend;   // held digit still to go out
    logic [CNT_W-1:0]      r_cnt,   n_cnt;    // own digits left in a non-last word
    // carried between words
    logic                  r_hvalid, n_hvalid;
    logic [1:0]            r_hbits,  n_hbits;
    logic                  r_carry,  n_carry;
    // output register
    logic                  r_ovalid, n_ovalid;
    logic [DIGIT_W-1:0]    r_digit,  n_digit;
    logic                  r_olast,  n_olast;

    logic               w_step;
    logic               w_emit;
    logic               w_is_last;
    logic               w_done;
    logic [2:0]         w_win;
    logic [DIGIT_W-1:0] w_sum;
    logic               w_load;

    assign w_step    = r_busy && (!r_ovalid || i_ready);
    assign o_q_ready = !r_busy || (w_step && w_done);
    assign w_load    = i_q_valid && o_q_ready;

    // window and digit for the current position
    always_comb begin
        w_win     = r_w[2:0];
        w_emit    = 1'b1;
        w_is_last = 1'b0;
        w_done    = 1'b0;
        if (r_pend) begin
            w_win     = {r_w[0], r_hbits};
            w_is_last = r_last && (r_w == '0);
            w_done    = w_is_last;
        end else if (!r_last) begin
            w_done = (r_cnt == CNT_W'(1));
        end else begin
            w_emit    = (r_w != '0);
            w_is_last = (r_w[WORD_WIDTH-1:2] == '0);
            w_done    = w_is_last;
        end
    end

    assign w_sum = {1'b0, w_win} + {{(DIGIT_W-1){1'b0}}, r_carry};

    always_comb begin
        n_busy   = r_busy;
        n_w      = r_w;
        n_last   = r_last;
        n_pend   = r_pend;
        n_cnt    = r_cnt;
        n_hvalid = r_hvalid;
        n_hbits  = r_hbits;
        n_carry  = r_carry;
        n_ovalid = r_ovalid;
        n_digit  = r_digit;
        n_olast  = r_olast;

        if (!r_ovalid || i_ready) begin
            n_ovalid = w_step && w_emit;
        end

        if (w_step) begin
            // most significant digit keeps the +4
            n_digit = w_is_last ? w_sum : w_sum - DIGIT_BIAS;
            n_olast = w_is_last;
            if (w_emit) begin
                n_carry = (w_sum < DIGIT_BIAS);
            end
            if (r_pend) begin
                n_pend = 1'b0;
            end else begin
                n_w   = r_w >> 2;
                n_cnt = r_cnt - CNT_W'(1);
            end
            if (w_done) begin
                n_busy = 1'b0;
                if (r_last) begin
                    n_hvalid = 1'b0;
                    n_hbits  = '0;
                    n_carry  = 1'b0;
                end else begin
                    // top two bits wait for bit 0 of the next word
                    n_hvalid = 1'b1;
                    n_hbits  = r_w[3:2];
                end
            end
        end

        if (w_load) begin
            n_w    = i_q_word;
            n_last = i_q_ctrl.last_word;
            n_pend = n_hvalid;
            n_cnt  = CNT_W'(HALF - 1);
            // a zero last word with nothing held yields no digit
            n_busy = !(i_q_ctrl.last_word && i_q_ctrl.word_zero && !n_hvalid);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_hvalid <= 1'b0;
            r_hbits  <= '0;
            r_carry  <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_busy   <= n_busy;
            r_hvalid <= n_hvalid;
            r_hbits  <= n_hbits;
            r_carry  <= n_carry;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_w     <= n_w;
        r_last  <= n_last;
        r_pend  <= n_pend;
        r_cnt   <= n_cnt;
        r_digit <= n_digit;
        r_olast <= n_olast;
    end

    assign o_valid = r_ovalid;
    assign o_digit = r_digit;
    assign o_last  = r_olast;

endmodule

`default_nettype wire

[src/srr_checker.sv]
// ----------------------------------------------------------------------------
// srr_checker
// port-level checks on the digit stream of the recoder
// ----------------------------------------------------------------------------
`default_nettype none

`include "signed_radix4_scalar_recoder_defines.svh"

module srr_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       m_axis_tvalid,
    input logic       m_axis_tready,
    input logic [7:0] m_axis_tdata,
    input logic       m_axis_tlast
);

    // digit stays within -4..4 and the pad bits stay zero
    `SRR_ASSERT_NOW(a_digit_range, i_clk, i_rst_n, m_axis_tvalid, (m_axis_tdata[7:4] == 4'd0) && (m_axis_tdata[3] ? (m_axis_tdata[2:0] >= 3'd4) : (m_axis_tdata[2:0] <= 3'd4)), "digit out of range")

    // the most significant digit carries the +4 and is never negative
    `SRR_ASSERT_NOW(a_last_nonneg, i_clk, i_rst_n, m_axis_tvalid && m_axis_tlast, !m_axis_tdata[3], "negative last digit")

    // a stalled word holds
    `SRR_ASSERT_NEXT(a_stall_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast), "output changed under stall")

endmodule

bind signed_radix4_scalar_recoder srr_checker u_srr_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire

[tb/signed_radix4_scalar_recoder_tb.sv]
// ----------------------------------------------------------------------------
// signed_radix4_scalar_recoder_tb
// streams multiword scalars into the recoder and checks every signed radix-4
// digit against an in-bench recoding of the same words or a typed expectation,
// under steady traffic, sender gaps, receiver stalls and both at once
// ----------------------------------------------------------------------------
`default_nettype none

module signed_radix4_scalar_recoder_tb;

    localparam int WORD_W         = srr_pkg::WORD_WIDTH_DEF;
    localparam int IN_TDATA_W     = ((WORD_W + 7) / 8) * 8;
    localparam int DIGIT_W        = srr_pkg::DIGIT_W;
    localparam int TOTAL_WORDS    = 410;
    localparam int SEG_WORDS      = 50;     // scalar words per traffic pattern
    localparam int HOLD_CYCLES    = 400;    // long receiver hold-off
    localparam int SETTLE_CYCLES  = 40;     // quiet time after the last digit
    localparam int WATCHDOG_LIMIT = 4000;   // cycles without any accepted word
    localparam int MAX_PRINTED    = 40;
    localparam int USE_PREDICTOR  = -1;     // table row checked by the recoding below

    // traffic patterns
    typedef enum logic [1:0] {
        PACE_STEADY,
        PACE_SRC_GAPS,
        PACE_SINK_STALLS,
        PACE_BOTH
    } t_pace;

    // one expected output word
    typedef struct packed {
        logic [DIGIT_W-1:0] digit;
        logic               last_digit;
    } t_digit;

    // one directed input word; typed_n >= 0 gives that many copies of
    // typed_digit, each marked last (only single-digit or empty scalars)
    typedef struct packed {
        logic [WORD_W-1:0]  word;
        logic               last;
        int                 typed_n;
        logic [DIGIT_W-1:0] typed_digit;
    } t_stim_row;

    localparam int DIRECTED_N = 20;

    t_stim_row directed_rows [DIRECTED_N] = '{
        // single-word scalars with results that can be read off directly
        '{32'h0000_0000, 1'b1, 0, 4'd0},            // all zero: no digits at all
        '{32'h0000_0001, 1'b1, 1, 4'd1},
        '{32'h0000_0002, 1'b1, 1, 4'd2},
        '{32'h0000_0003, 1'b1, 1, 4'd3},
        // extremes of a lone last word
        '{32'hFFFF_FFFF, 1'b1, USE_PREDICTOR, 4'd0},
        '{32'h8000_0000, 1'b1, USE_PREDICTOR, 4'd0},
        '{32'h5555_5555, 1'b1, USE_PREDICTOR, 4'd0},
        // last word with no digits of its own: held digit closes the scalar
        '{32'hFFFF_FFFF, 1'b0, USE_PREDICTOR, 4'd0},
        '{32'h0000_0000, 1'b1, USE_PREDICTOR, 4'd0},
        '{32'h0000_0000, 1'b0, USE_PREDICTOR, 4'd0},
        '{32'h0000_0000, 1'b1, USE_PREDICTOR, 4'd0},
        // held digit plus a full last word: most digits for one word
        '{32'hAAAA_AAAA, 1'b0, USE_PREDICTOR, 4'd0},
        '{32'h7FFF_FFFF, 1'b0, USE_PREDICTOR, 4'd0},
        '{32'hC000_0000, 1'b1, USE_PREDICTOR, 4'd0},
        '{32'h8000_0000, 1'b0, USE_PREDICTOR, 4'd0},
        '{32'h0000_0001, 1'b1, USE_PREDICTOR, 4'd0},
        // four-word scalar with a zero top word
        '{32'h1234_5678, 1'b0, USE_PREDICTOR, 4'd0},
        '{32'hFFFF_FFFF, 1'b0, USE_PREDICTOR, 4'd0},
        '{32'h0000_0001, 1'b0, USE_PREDICTOR, 4'd0},
        '{32'h0000_0000, 1'b1, USE_PREDICTOR, 4'd0}
    };

    // ------------------------------------------------------------------------
    // clock, reset and port signals
    // ------------------------------------------------------------------------
    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;      // scalar_word
    logic                   s_axis_tlast = 1'b0;    // last_word
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [srr_pkg::OUT_TDATA_W-1:0] m_axis_tdata;  // digit, zero pad
    logic                   m_axis_tlast;           // last_digit

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    signed_radix4_scalar_recoder #(
        .WORD_WIDTH(WORD_W)
    ) uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    // ------------------------------------------------------------------------
    // recoding of the scalar words, kept in step with the accepted input
    // ------------------------------------------------------------------------
    logic [1:0]  held_bits = 2'b00;    // top two bits of the previous word
    logic        held_cy = 1'b0;       // carry into the held digit
    logic        held_on = 1'b0;       // a held digit is pending
    t_digit      fresh_digits [$];     // digits caused by the latest word
    t_digit      pending_digits [$];   // digits still owed by the block

    function automatic void recode_word(input logic [WORD_W-1:0] w, input logic last);
        int   windows [$];
        int   d;
        int   j;
        logic cy;
        logic top;
        fresh_digits.delete();
        cy = held_on ? held_cy : 1'b0;
        // held digit takes bit 0 of this word as its window top
        if (held_on)
            windows.push_back(int'(held_bits) + (w[0] ? 4 : 0));
        if (!last) begin
            for (j = 0; j + 2 < WORD_W; j += 2)
                windows.push_back(int'(w >> j) & 7);
        end else begin
            // last word: only while higher bits remain
            for (j = 0; j < WORD_W && (w >> j) != 0; j += 2)
                windows.push_back(int'(w >> j) & 7);
        end
        foreach (windows[i]) begin
            d   = windows[i] + int'(cy) - 4;
            cy  = (d < 0);
            top = last && (i == windows.size() - 1);
            if (top)
                d += 4;
            fresh_digits.push_back(t_digit'{d[DIGIT_W-1:0], top});
        end
        if (last) begin
            held_bits = 2'b00;
            held_cy   = 1'b0;
            held_on   = 1'b0;
        end else begin
            held_bits = w[WORD_W-1 -: 2];
            held_cy   = cy;
            held_on   = 1'b1;
        end
    endfunction

    // ------------------------------------------------------------------------
    // traffic pattern control
    // ------------------------------------------------------------------------
    t_pace pace = PACE_STEADY;
    logic  hold_req = 1'b0;    // asks the receiver for one long hold-off
    int    hold_left = 0;

    function automatic int src_gap_pct(input t_pace p);
        case (p)
            PACE_SRC_GAPS: return 88;
            PACE_BOTH:     return 26;
            default:       return 0;
        endcase
    endfunction

    function automatic int sink_stall_pct(input t_pace p);
        case (p)
            PACE_SINK_STALLS: return 88;
            PACE_BOTH:        return 26;
            default:          return 0;
        endcase
    endfunction

    // receiver: random stalls, or a counted hold-off on request
    always @(posedge i_clk) begin
        if (hold_req) begin
            hold_req      <= 1'b0;
            hold_left     <= HOLD_CYCLES;
            m_axis_tready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left     <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(0, 99) >= sink_stall_pct(pace));
        end
    end

    // ------------------------------------------------------------------------
    // checking
    // ------------------------------------------------------------------------
    int mismatches = 0;
    int quiet_cycles = 0;
    int drv_typed_n = USE_PREDICTOR;            // travels with the driven word
    logic [DIGIT_W-1:0] drv_typed_digit = '0;

    task automatic report_mismatch(input string what);
        mismatches++;
        if (mismatches <= MAX_PRINTED)
            $display("[%0t] mismatch: %s", $realtime, what);
    endtask

    always @(posedge i_clk) begin : monitor
        t_digit want;
        logic   in_word;
        logic   out_word;
        in_word  = i_rst_n && s_axis_tvalid && (s_axis_tready === 1'b1);
        out_word = i_rst_n && (m_axis_tvalid === 1'b1) && m_axis_tready;

        // expectations first, so a word accepted now is never matched early
        if (in_word) begin
            recode_word(s_axis_tdata[WORD_W-1:0], s_axis_tlast);
            if (drv_typed_n == USE_PREDICTOR) begin
                foreach (fresh_digits[i])
                    pending_digits.push_back(fresh_digits[i]);
            end else begin
                for (int k = 0; k < drv_typed_n; k++)
                    pending_digits.push_back(t_digit'{drv_typed_digit, 1'b1});
            end
        end

        if (out_word) begin
            if (pending_digits.size() == 0) begin
                report_mismatch($sformatf("digit %0d (last %0b) with none expected",
                                          $signed(m_axis_tdata[DIGIT_W-1:0]), m_axis_tlast));
            end else begin
                want = pending_digits.pop_front();
                if (m_axis_tdata[DIGIT_W-1:0] !== want.digit)
                    report_mismatch($sformatf("digit %0d, expected %0d",
                                              $signed(m_axis_tdata[DIGIT_W-1:0]),
                                              $signed(want.digit)));
                if (m_axis_tlast !== want.last_digit)
                    report_mismatch($sformatf("last_digit %0b, expected %0b",
                                              m_axis_tlast, want.last_digit));
            end
        end

        // watchdog on stretches without any accepted word
        if (!i_rst_n || in_word || out_word) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("timeout: no word accepted for %0d cycles", WATCHDOG_LIMIT);
                $display("** signed_radix4_scalar_recoder: FAILED **");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------------
    int words_sent = 0;

    // offers one scalar word, returns just after the edge that takes it
    task automatic send_word(input logic [WORD_W-1:0] w, input logic last,
                             input int typed_n, input logic [DIGIT_W-1:0] typed_digit);
        while ($urandom_range(0, 99) < src_gap_pct(pace)) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid   <= 1'b1;
        s_axis_tdata    <= IN_TDATA_W'(w);
        s_axis_tlast    <= last;
        drv_typed_n     <= typed_n;
        drv_typed_digit <= typed_digit;
        @(posedge i_clk);
        while (s_axis_tready !== 1'b1)
            @(posedge i_clk);
        words_sent++;
    endtask

    // sender pause until the block has delivered everything it owes
    task automatic wait_digits_drained();
        s_axis_tvalid <= 1'b0;
        do
            @(posedge i_clk);
        while (pending_digits.size() != 0);
    endtask

    // words biased toward zero, all ones, single bits and short lengths
    function automatic logic [WORD_W-1:0] pick_word();
        logic [WORD_W-1:0] w;
        case ($urandom_range(0, 9))
            0:       w = '0;
            1:       w = '1;
            2:       w = WORD_W'(1) << $urandom_range(0, WORD_W - 1);
            3:       w = WORD_W'($urandom) >> $urandom_range(1, WORD_W - 1);
            4:       w = ~(WORD_W'($urandom) >> $urandom_range(1, WORD_W - 1));
            default: w = WORD_W'($urandom);
        endcase
        return w;
    endfunction

    initial begin : stimulus
        int   n_words;
        int   seg_words;
        logic hold_done;
        seg_words = 0;
        hold_done = 1'b0;

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed table, steady traffic
        foreach (directed_rows[r])
            send_word(directed_rows[r].word, directed_rows[r].last,
                      directed_rows[r].typed_n, directed_rows[r].typed_digit);
        wait_digits_drained();

        // random scalars, traffic pattern rotated every segment
        while (words_sent < TOTAL_WORDS) begin
            if (seg_words >= SEG_WORDS) begin
                wait_digits_drained();
                pace      = t_pace'((int'(pace) + 1) % 4);
                seg_words = 0;
            end
            // one long receiver hold-off while words keep coming
            if (!hold_done && pace == PACE_STEADY) begin
                hold_req  <= 1'b1;
                hold_done = 1'b1;
            end
            n_words = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 8)
                                                  : $urandom_range(1, 3);
            for (int i = 0; i < n_words; i++)
                send_word(pick_word(), i == n_words - 1, USE_PREDICTOR, '0);
            seg_words += n_words;
        end

        wait_digits_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatches == 0)
            $display("** signed_radix4_scalar_recoder: PASSED **");
        else
            $display("** signed_radix4_scalar_recoder: FAILED **");
        $finish;
    end

endmodule

`default_nettype wire

[sim.f]
+incdir+src
src/srr_pkg.sv
src/srr_front.sv
src/srr_back.sv
src/signed_radix4_scalar_recoder.sv
src/srr_checker.sv
tb/signed_radix4_scalar_recoder_tb.sv
